// File: src/hrfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfd_pkg
// Types and constants shared by the H.264 RTP FU-A depacketizer.
// ----------------------------------------------------------------------------
package hrfd_pkg;

    // NAL header fields
    localparam logic [7:0] NAL_TYPE_MASK  = 8'h1F;
    localparam logic [7:0] NAL_FNRI_MASK  = 8'hE0;
    localparam logic [7:0] FU_START_BIT   = 8'h80;
    localparam logic [7:0] FU_END_BIT     = 8'h40;
    localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;
    localparam logic [4:0] NAL_TYPE_SMAX  = 5'd23;
    localparam logic [4:0] NAL_TYPE_STAPA = 5'd24;
    localparam logic [4:0] NAL_TYPE_FUA   = 5'd28;

    // Packet handling mode
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SINGLE  = 3'd1,
        MODE_FU_HDR  = 3'd2,
        MODE_FU_DATA = 3'd3,
        MODE_DROP    = 3'd4
    } mode_t;

    // Result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    // Packet status codes
    localparam logic [2:0] STAT_SINGLE   = 3'd0;
    localparam logic [2:0] STAT_PENDING  = 3'd1;
    localparam logic [2:0] STAT_COMPLETE = 3'd2;
    localparam logic [2:0] STAT_GAP      = 3'd3;
    localparam logic [2:0] STAT_INVALID  = 3'd4;

    // Result slot order within one input transfer
    localparam int SLOT_DISCARD = 0;
    localparam int SLOT_DATA    = 1;
    localparam int SLOT_STATUS  = 2;
    localparam int NUM_SLOTS    = 3;

    // Input item
    typedef struct packed {
        logic [31:0] rtp_timestamp;
        logic [15:0] sequence_number;
        logic        packet_empty;
        logic        packet_last;
        logic        packet_first;
        logic [7:0]  payload_byte;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [2:0]  packet_status;
        logic [31:0] nal_timestamp;
        logic        key_frame;
        logic        nal_start;
        logic        from_fragments;
        logic [7:0]  nal_byte;
        logic [1:0]  result_kind;
    } result_t;

    // All results of one input transfer
    typedef struct packed {
        logic [NUM_SLOTS-1:0]           valid;
        result_t [NUM_SLOTS-1:0]        res;
    } res_bundle_t;

endpackage : hrfd_pkg
`default_nettype wire

// File: src/hrfd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfd_core
// Packet and reassembly state, and the results that one payload byte causes.
// ----------------------------------------------------------------------------
module hrfd_core
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire hrfd_pkg::in_item_t   item,
    output hrfd_pkg::res_bundle_t     bundle
);
    import hrfd_pkg::*;

    mode_t       mode_reg, mode_next;
    logic        active_reg, active_next;
    logic [31:0] fts_reg, fts_next;
    logic [15:0] exp_reg, exp_next;
    logic [4:0]  otype_reg, otype_next;
    logic [7:0]  ind_reg, ind_next;
    logic [2:0]  pend_reg, pend_next;

    // Decoded fields of the current byte
    logic [4:0]  byte_type;
    logic        fu_s, fu_e;
    logic        single_type;
    logic        seq_ok, ts_ok;

    assign byte_type   = item.payload_byte[4:0] & NAL_TYPE_MASK[4:0];
    assign fu_s        = |(item.payload_byte & FU_START_BIT);
    assign fu_e        = |(item.payload_byte & FU_END_BIT);
    assign single_type = (byte_type != 5'd0) && (byte_type <= NAL_TYPE_SMAX);
    assign seq_ok      = (item.sequence_number == exp_reg);
    assign ts_ok       = (item.rtp_timestamp == fts_reg);

    // Next state
    always_comb
    begin
        mode_next   = mode_reg;
        active_next = active_reg;
        fts_next    = fts_reg;
        exp_next    = exp_reg;
        otype_next  = otype_reg;
        ind_next    = ind_reg;
        pend_next   = pend_reg;
        if (item.packet_empty)
        begin
            mode_next = MODE_IDLE;
        end
        else if (item.packet_first || (mode_reg != MODE_IDLE))
        begin
            if (item.packet_first)
            begin
                ind_next = item.payload_byte;
                if (single_type)
                begin
                    mode_next = MODE_SINGLE;
                    pend_next = STAT_SINGLE;
                end
                else if (byte_type == NAL_TYPE_FUA)
                begin
                    mode_next = MODE_FU_HDR;
                    pend_next = STAT_INVALID;
                end
                else
                begin
                    // STAP-A and every other type
                    mode_next = MODE_DROP;
                    pend_next = STAT_INVALID;
                end
            end
            else if (mode_reg == MODE_FU_HDR)
            begin
                priority if (fu_s)
                begin
                    active_next = 1'b1;
                    fts_next    = item.rtp_timestamp;
                    exp_next    = item.sequence_number + 16'd1;
                    otype_next  = byte_type;
                    mode_next   = MODE_FU_DATA;
                    pend_next   = fu_e ? STAT_COMPLETE : STAT_PENDING;
                end
                else if (!active_reg)
                begin
                    mode_next = MODE_DROP;
                    pend_next = STAT_GAP;
                end
                else if (!seq_ok || !ts_ok)
                begin
                    active_next = 1'b0;
                    fts_next    = '0;
                    exp_next    = '0;
                    otype_next  = '0;
                    mode_next   = MODE_DROP;
                    pend_next   = seq_ok ? STAT_INVALID : STAT_GAP;
                end
                else
                begin
                    exp_next  = item.sequence_number + 16'd1;
                    mode_next = MODE_FU_DATA;
                    pend_next = fu_e ? STAT_COMPLETE : STAT_PENDING;
                end
            end
            // packet end: finished reassembly returns to reset values
            if (item.packet_last)
            begin
                if ((mode_next == MODE_FU_DATA) && (pend_next == STAT_COMPLETE))
                begin
                    active_next = 1'b0;
                    fts_next    = '0;
                    exp_next    = '0;
                    otype_next  = '0;
                end
                mode_next = MODE_IDLE;
            end
        end
    end

    // Results of this byte: discard, data, status
    always_comb
    begin
        bundle       = '0;
        bundle.res[SLOT_DISCARD].result_kind    = KIND_DISCARD;
        bundle.res[SLOT_DISCARD].from_fragments = 1'b1;
        bundle.res[SLOT_DATA].result_kind       = KIND_DATA;
        bundle.res[SLOT_STATUS].result_kind     = KIND_STATUS;

        if (item.packet_empty)
        begin
            bundle.valid[SLOT_STATUS]             = 1'b1;
            bundle.res[SLOT_STATUS].packet_status = STAT_INVALID;
        end
        else if (item.packet_first || (mode_reg != MODE_IDLE))
        begin
            if (item.packet_first)
            begin
                bundle.valid[SLOT_DATA]             = single_type;
                bundle.res[SLOT_DATA].nal_byte      = item.payload_byte;
                bundle.res[SLOT_DATA].nal_start     = 1'b1;
                bundle.res[SLOT_DATA].key_frame     = (byte_type == NAL_TYPE_IDR);
                bundle.res[SLOT_DATA].nal_timestamp = item.rtp_timestamp;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_SINGLE:
                    begin
                        bundle.valid[SLOT_DATA]             = 1'b1;
                        bundle.res[SLOT_DATA].nal_byte      = item.payload_byte;
                        bundle.res[SLOT_DATA].key_frame     = (ind_reg[4:0] == NAL_TYPE_IDR);
                        bundle.res[SLOT_DATA].nal_timestamp = item.rtp_timestamp;
                    end
                    MODE_FU_HDR:
                    begin
                        bundle.valid[SLOT_DISCARD] = active_reg && (fu_s || !seq_ok || !ts_ok);
                        bundle.valid[SLOT_DATA]    = fu_s;
                        bundle.res[SLOT_DATA].nal_byte =
                            (ind_reg & NAL_FNRI_MASK) | {3'b000, byte_type};
                        bundle.res[SLOT_DATA].from_fragments = 1'b1;
                        bundle.res[SLOT_DATA].nal_start      = 1'b1;
                        bundle.res[SLOT_DATA].key_frame      = (byte_type == NAL_TYPE_IDR);
                        bundle.res[SLOT_DATA].nal_timestamp  = item.rtp_timestamp;
                    end
                    MODE_FU_DATA:
                    begin
                        bundle.valid[SLOT_DATA]              = 1'b1;
                        bundle.res[SLOT_DATA].nal_byte       = item.payload_byte;
                        bundle.res[SLOT_DATA].from_fragments = 1'b1;
                        bundle.res[SLOT_DATA].key_frame      = (otype_reg == NAL_TYPE_IDR);
                        bundle.res[SLOT_DATA].nal_timestamp  = fts_reg;
                    end
                    default:
                    begin
                        // idle or dropping: no data
                    end
                endcase
            end
            bundle.valid[SLOT_STATUS]             = item.packet_last;
            bundle.res[SLOT_STATUS].packet_status = pend_next;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            active_reg <= 1'b0;
            fts_reg    <= '0;
            exp_reg    <= '0;
            otype_reg  <= '0;
            ind_reg    <= '0;
            pend_reg   <= STAT_SINGLE;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            active_reg <= active_next;
            fts_reg    <= fts_next;
            exp_reg    <= exp_next;
            otype_reg  <= otype_next;
            ind_reg    <= ind_next;
            pend_reg   <= pend_next;
        end
    end

endmodule : hrfd_core
`default_nettype wire

// File: src/hrfd_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfd_outbuf
// Result register: holds the results of one input transfer and hands them
// out one per output transfer, in slot order.
// ----------------------------------------------------------------------------
module hrfd_outbuf
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire hrfd_pkg::res_bundle_t bundle,
    output logic                       load_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hrfd_pkg::result_t          out_res,
    output logic [1:0]                 occupancy
);
    import hrfd_pkg::*;

    result_t [NUM_SLOTS-1:0] slot_reg;
    logic [NUM_SLOTS-1:0]    valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]    head;
    logic                    pop;

    // lowest valid slot goes out first
    assign head      = valid_reg & (~valid_reg + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
    assign out_valid = |valid_reg;
    assign pop       = out_valid && out_ready;
    assign occupancy = 2'($countones(valid_reg));
    assign load_ready = (valid_reg == '0) || ((occupancy == 2'd1) && out_ready);

    always_comb
    begin
        out_res = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (head[i])
            begin
                out_res = slot_reg[i];
            end
        end
    end

    always_comb
    begin
        valid_next = pop ? (valid_reg & ~head) : valid_reg;
        if (load)
        begin
            valid_next = bundle.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= bundle.res;
        end
    end

endmodule : hrfd_outbuf
`default_nettype wire

// File: src/h264_rtp_fua_depacketizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h264_rtp_fua_depacketizer
// H.264 RTP depacketizer for single NAL unit and FU-A packets.
// ----------------------------------------------------------------------------
// One payload byte is taken per cycle while s_tready is high. Each byte is
// decoded combinationally against the packet and reassembly state and its
// results (a discard, a NAL byte and a packet status, in that order, each
// optional) land in a result register that drains at one transfer per cycle
// while m_tready is high. A byte with at most one result keeps the full input
// rate; after two or three results the next byte waits until the single output
// port has drained the register to its last result. Bytes with no result, such
// as an FU-A indicator, are still taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module h264_rtp_fua_depacketizer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // payload_byte, sequence_number, rtp_timestamp
    input  wire logic [1:0]  s_tuser,   // packet_first, packet_empty
    input  wire logic        s_tlast,   // packet_last
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // nal_byte, nal_start, key_frame, nal_timestamp,
                                        // packet_status, 3 zero bits
    output logic [2:0]       m_tuser    // result_kind, from_fragments
);
    import hrfd_pkg::*;

    in_item_t    item;
    res_bundle_t bundle;
    result_t     out_res;
    logic        accept;
    logic [1:0]  occupancy;

    // unpack input transfer
    assign item.payload_byte    = s_tdata[7:0];
    assign item.sequence_number = s_tdata[23:8];
    assign item.rtp_timestamp   = s_tdata[55:24];
    assign item.packet_first    = s_tuser[0];
    assign item.packet_empty    = s_tuser[1];
    assign item.packet_last     = s_tlast;

    assign accept = s_tvalid && s_tready;

    hrfd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .bundle (bundle)
    );

    hrfd_outbuf u_outbuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .bundle     (bundle),
        .load_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res),
        .occupancy  (occupancy)
    );

    // pack result transfer
    assign m_tdata = {3'b000, out_res.packet_status, out_res.nal_timestamp,
                      out_res.key_frame, out_res.nal_start, out_res.nal_byte};
    assign m_tuser = {out_res.from_fragments, out_res.result_kind};

`ifndef ASSERT_OFF
    // never take a byte while more than one result is still waiting
    a_ready_occ: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (occupancy <= 2'd1))
        else $error("input ready with results still queued");

    // last queued result taken with nothing new leaves the output idle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (occupancy == 2'd1 && m_tvalid && m_tready && !s_tvalid) |=> !m_tvalid)
        else $error("result register did not drain");

    // an empty packet always yields a status
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser[1]) |=> (m_tvalid && m_tuser[1:0] == KIND_STATUS))
        else $error("empty packet gave no status");
`endif

endmodule : h264_rtp_fua_depacketizer
`default_nettype wire

// File: tb/tb_h264_rtp_fua_depacketizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_h264_rtp_fua_depacketizer
// Self-checking bench for the H.264 RTP single NAL / FU-A depacketizer.
// ----------------------------------------------------------------------------
// Payload bytes are streamed in as whole packets. Every accepted byte is run
// through a behavioural depacketizer in the bench, and the NAL bytes, discard
// marks and packet status it predicts are queued. Each result transfer is
// compared field by field against the head of that queue. Directed packets hit
// the corner cases of FU-A reassembly and the packet marks. Random traffic
// then mixes single NAL units, fragment runs with injected sequence and
// timestamp faults, and malformed packets, with random gaps and stalls; one
// long output hold-off comes before it.
// ----------------------------------------------------------------------------
module tb_h264_rtp_fua_depacketizer;

    import hrfd_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int SINK_HOLD_CYCLES = 200;
    localparam int STALL_LIMIT      = 1000;
    localparam int DRAIN_CYCLES     = 16;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // payload_byte, sequence_number, rtp_timestamp
    logic [1:0]  s_tuser;   // packet_first, packet_empty
    logic        s_tlast;   // packet_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;   // nal_byte, nal_start, key_frame, nal_timestamp,
                            // packet_status, 3 zero bits
    logic [2:0]  m_tuser;   // result_kind, from_fragments

    // bench-side depacketizer state
    logic        fu_active   = 1'b0;
    logic [31:0] fu_ts       = '0;
    logic [15:0] fu_next_seq = '0;
    logic [4:0]  fu_type     = '0;
    logic [7:0]  pkt_hdr     = '0;
    mode_t       pkt_mode    = MODE_IDLE;
    logic [2:0]  pkt_status  = STAT_SINGLE;

    result_t nal_results_due[$];

    // traffic generator state
    logic [15:0] gen_seq   = 16'h0100;
    logic [31:0] frag_ts   = '0;
    logic        frag_open = 1'b0;

    bit src_idle_en   = 1'b1;
    bit sink_idle_en  = 1'b1;
    bit sink_hold_req = 1'b0;

    int bytes_sent       = 0;
    int results_checked  = 0;
    int discards_checked = 0;
    int fail_count       = 0;
    int idle_cycles      = 0;

    h264_rtp_fua_depacketizer uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void push_data(input logic [7:0] nb, input logic frag,
                                      input logic start, input logic key,
                                      input logic [31:0] ts);
        result_t r;
        r                = '0;
        r.result_kind    = KIND_DATA;
        r.nal_byte       = nb;
        r.from_fragments = frag;
        r.nal_start      = start;
        r.key_frame      = key;
        r.nal_timestamp  = ts;
        nal_results_due  = {nal_results_due, r};
    endfunction

    function automatic void push_status(input logic [2:0] st);
        result_t r;
        r               = '0;
        r.result_kind   = KIND_STATUS;
        r.packet_status = st;
        nal_results_due = {nal_results_due, r};
    endfunction

    function automatic void push_discard();
        result_t r;
        r                = '0;
        r.result_kind    = KIND_DISCARD;
        r.from_fragments = 1'b1;
        nal_results_due  = {nal_results_due, r};
    endfunction

    function automatic void clear_reassembly();
        fu_active   = 1'b0;
        fu_ts       = '0;
        fu_next_seq = '0;
        fu_type     = '0;
    endfunction

    // Works out the results one accepted payload byte causes
    function automatic void depacketize_byte(input logic [7:0] pb, input logic is_first,
                                             input logic is_last, input logic is_empty,
                                             input logic [15:0] seq,
                                             input logic [31:0] ts);
        logic [4:0] t;
        t = pb[4:0];

        // empty payload ends any packet, reassembly left alone
        if (is_empty)
        begin
            pkt_mode = MODE_IDLE;
            push_status(STAT_INVALID);
            return;
        end

        if (is_first)
        begin
            pkt_hdr = pb;
            if (t != 5'd0 && t <= NAL_TYPE_SMAX)
            begin
                pkt_mode   = MODE_SINGLE;
                pkt_status = STAT_SINGLE;
                push_data(pb, 1'b0, 1'b1, t == NAL_TYPE_IDR, ts);
            end
            else if (t == NAL_TYPE_FUA)
            begin
                pkt_mode   = MODE_FU_HDR;
                pkt_status = STAT_INVALID;
            end
            else
            begin
                pkt_mode   = MODE_DROP;
                pkt_status = STAT_INVALID;
            end
        end
        else
        begin
            // stray byte with no packet open
            if (pkt_mode == MODE_IDLE)
                return;
            case (pkt_mode)
                MODE_SINGLE:
                    push_data(pb, 1'b0, 1'b0, pkt_hdr[4:0] == NAL_TYPE_IDR, ts);
                MODE_FU_HDR:
                begin
                    if ((pb & FU_START_BIT) != 8'h00)
                    begin
                        if (fu_active)
                            push_discard();
                        fu_active   = 1'b1;
                        fu_ts       = ts;
                        fu_next_seq = seq + 16'd1;
                        fu_type     = t;
                        push_data((pkt_hdr & NAL_FNRI_MASK) | {3'b000, t}, 1'b1, 1'b1,
                                  t == NAL_TYPE_IDR, ts);
                        pkt_mode   = MODE_FU_DATA;
                        pkt_status = ((pb & FU_END_BIT) != 8'h00) ? STAT_COMPLETE
                                                                   : STAT_PENDING;
                    end
                    else if (!fu_active)
                    begin
                        pkt_mode   = MODE_DROP;
                        pkt_status = STAT_GAP;
                    end
                    else if (seq != fu_next_seq)
                    begin
                        clear_reassembly();
                        push_discard();
                        pkt_mode   = MODE_DROP;
                        pkt_status = STAT_GAP;
                    end
                    else if (ts != fu_ts)
                    begin
                        clear_reassembly();
                        push_discard();
                        pkt_mode   = MODE_DROP;
                        pkt_status = STAT_INVALID;
                    end
                    else
                    begin
                        fu_next_seq = seq + 16'd1;
                        pkt_mode    = MODE_FU_DATA;
                        pkt_status  = ((pb & FU_END_BIT) != 8'h00) ? STAT_COMPLETE
                                                                    : STAT_PENDING;
                    end
                end
                MODE_FU_DATA:
                    push_data(pb, 1'b1, 1'b0, fu_type == NAL_TYPE_IDR, fu_ts);
                default: ;
            endcase
        end

        // packet close: status, and a finished reassembly is released
        if (is_last)
        begin
            push_status(pkt_status);
            if (pkt_mode == MODE_FU_DATA && pkt_status == STAT_COMPLETE)
                clear_reassembly();
            pkt_mode = MODE_IDLE;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Called on a rising edge; returns on the edge where the transfer happens
    task automatic send_byte(input logic [7:0] pb, input logic is_first, input logic is_last,
                             input logic is_empty, input logic [15:0] seq,
                             input logic [31:0] ts);
        bit took;
        if (src_idle_en && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, seq, pb};
        s_tuser  <= {is_empty, is_first};
        s_tlast  <= is_last;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        bytes_sent++;
        depacketize_byte(pb, is_first, is_last, is_empty, seq, ts);
    endtask

    task automatic send_packet(input byte_q_t pkt, input logic [15:0] seq,
                               input logic [31:0] ts, input logic closed);
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == 0, closed && i == pkt.size() - 1, 1'b0, seq, ts);
    endtask

    // Sender stops and waits for every predicted result to be seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (nal_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [4:0] pick_nal_type();
        if ($urandom_range(2) == 0)
            return NAL_TYPE_IDR;
        return 5'($urandom_range(1, 23));
    endfunction

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    // Receiver ready, with random stalls and an on-request long hold-off
    initial
    begin : result_sink
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !(sink_idle_en && $urandom_range(99) < 30);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Outputs are stable at the falling edge before the transfer edge
    always @(negedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.result_kind    = m_tuser[1:0];
            got.from_fragments = m_tuser[2];
            got.nal_byte       = m_tdata[7:0];
            got.nal_start      = m_tdata[8];
            got.key_frame      = m_tdata[9];
            got.nal_timestamp  = m_tdata[41:10];
            got.packet_status  = m_tdata[44:42];
            results_checked++;
            if (nal_results_due.size() == 0)
            begin
                $error("result transfer with none due: kind %0d", got.result_kind);
                fail_count++;
            end
            else
            begin
                want = nal_results_due.pop_front();
                if (want.result_kind == KIND_DISCARD)
                    discards_checked++;
                check_field("result_kind", want.result_kind, got.result_kind);
                check_field("nal_byte", want.nal_byte, got.nal_byte);
                check_field("from_fragments", want.from_fragments, got.from_fragments);
                check_field("nal_start", want.nal_start, got.nal_start);
                check_field("key_frame", want.key_frame, got.key_frame);
                check_field("nal_timestamp", want.nal_timestamp, got.nal_timestamp);
                check_field("packet_status", want.packet_status, got.packet_status);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transfer for %0d cycles, %0d results still due",
               STALL_LIMIT, nal_results_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_single_nalu();
        // IDR with F and NRI set, extreme sequence and timestamp
        send_packet('{8'hE5, 8'hFF}, 16'h0000, 32'hFFFF_FFFF, 1'b1);
        // highest single type, one-byte packet
        send_packet('{8'h17}, 16'hFFFF, 32'h0000_0000, 1'b1);
    endtask

    task automatic test_fua_reassembly();
        // start fragment of an IDR, then the end fragment across sequence wrap
        send_packet('{8'h7C, 8'h85, 8'hAB}, 16'hFFFF, 32'h0000_1234, 1'b1);
        send_packet('{8'hFC, 8'h45}, 16'h0000, 32'h0000_1234, 1'b1);
        // start and end bits in one fragment
        send_packet('{8'h3C, 8'hC1, 8'h00}, 16'h0010, 32'h0000_0005, 1'b1);
    endtask

    task automatic test_fua_faults();
        // indicator with no fragment header
        send_packet('{8'h1C}, 16'h0020, 32'h0000_0007, 1'b1);
        // timestamp changes mid reassembly
        send_packet('{8'h7C, 8'h81}, 16'h0021, 32'h0000_0007, 1'b1);
        send_packet('{8'h7C, 8'h01}, 16'h0022, 32'h0000_0008, 1'b1);
        // fresh start fragment while one is open
        send_packet('{8'h7C, 8'h87}, 16'h0030, 32'h0000_0009, 1'b1);
        send_packet('{8'h7C, 8'h88}, 16'h0031, 32'h0000_0009, 1'b1);
        // sequence jump, then an end fragment with nothing open
        send_packet('{8'h7C, 8'h01}, 16'h0040, 32'h0000_0009, 1'b1);
        send_packet('{8'h5C, 8'h41}, 16'h0041, 32'h0000_0009, 1'b1);
    endtask

    task automatic test_invalid_packets();
        send_packet('{8'h18, 8'h00}, 16'h0050, 32'h0000_0010, 1'b1);
        send_byte(8'h55, 1'b1, 1'b1, 1'b1, 16'h0051, 32'h0000_0011);
    endtask

    task automatic test_packet_marks();
        // byte with no start mark while idle is dropped silently
        send_byte(8'h42, 1'b0, 1'b1, 1'b0, 16'h0060, 32'h0000_0012);
        // packet left open, then a new one starts
        send_byte(8'h41, 1'b1, 1'b0, 1'b0, 16'h0061, 32'h0000_0013);
        send_packet('{8'h41}, 16'h0062, 32'h0000_0014, 1'b1);
    endtask

    // Output held off while a long packet is offered, so the input stalls
    task automatic test_backpressure();
        byte_q_t pkt;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        pkt = {pkt, {3'd3, NAL_TYPE_IDR}};
        repeat (39) pkt = {pkt, 8'($urandom)};
        sink_hold_req = 1'b1;
        send_packet(pkt, gen_seq, $urandom, 1'b1);
        gen_seq++;
        wait_drained();
    endtask

    task automatic test_random_streams(input int n_bytes, input bit idle_on);
        int          stop_at;
        byte_q_t     pkt;
        logic [7:0]  fu_hdr;
        logic [15:0] seq_use;
        logic [31:0] ts_use;
        logic [4:0]  t;
        int          pick;
        stop_at      = bytes_sent + n_bytes;
        src_idle_en  = idle_on;
        sink_idle_en = idle_on;
        while (bytes_sent < stop_at)
        begin
            pkt  = {};
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                // single NAL unit
                pkt = {pkt, {3'($urandom_range(7)), pick_nal_type()}};
                repeat ($urandom_range(0, 5)) pkt = {pkt, 8'($urandom)};
                send_packet(pkt, gen_seq, $urandom, 1'b1);
                gen_seq++;
            end
            else if (pick < 82)
            begin
                // FU-A fragment, mostly continuing the open run
                if (!frag_open || $urandom_range(9) == 0)
                begin
                    if ($urandom_range(3) == 0)
                        gen_seq = 16'($urandom);
                    frag_ts = $urandom;
                    fu_hdr  = FU_START_BIT | {3'b000, pick_nal_type()};
                    if ($urandom_range(4) == 0)
                        fu_hdr = fu_hdr | FU_END_BIT;
                end
                else
                begin
                    fu_hdr = 8'($urandom_range(63));
                    if ($urandom_range(99) < 35)
                        fu_hdr = fu_hdr | FU_END_BIT;
                end
                frag_open = (fu_hdr & FU_END_BIT) == 8'h00;
                seq_use   = gen_seq;
                ts_use    = frag_ts;
                case ($urandom_range(19))
                    0:       seq_use = gen_seq + 16'($urandom_range(1, 500));
                    1:       ts_use  = frag_ts ^ (32'h1 << $urandom_range(31));
                    default: ;
                endcase
                if (seq_use != gen_seq || ts_use != frag_ts)
                    frag_open = 1'b0;
                pkt = {pkt, {3'($urandom_range(7)), NAL_TYPE_FUA}};
                pkt = {pkt, fu_hdr};
                repeat ($urandom_range(0, 4)) pkt = {pkt, 8'($urandom)};
                send_packet(pkt, seq_use, ts_use, 1'b1);
                gen_seq = seq_use + 16'd1;
            end
            else
            begin
                // malformed and odd packets
                case ($urandom_range(5))
                    0:
                        send_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'b1,
                                  gen_seq, $urandom);
                    1:
                    begin
                        t = 5'($urandom_range(24, 31));
                        if (t == NAL_TYPE_FUA)
                            t = 5'd0;
                        pkt = {pkt, {3'($urandom_range(7)), t}};
                        repeat ($urandom_range(0, 3)) pkt = {pkt, 8'($urandom)};
                        send_packet(pkt, gen_seq, $urandom, 1'b1);
                    end
                    2:
                        send_byte(8'($urandom), 1'b0, 1'($urandom), 1'b0, gen_seq, $urandom);
                    3:
                    begin
                        // packet that never sees its last mark
                        if ($urandom_range(1) == 0)
                        begin
                            pkt    = {pkt, {3'($urandom_range(7)), pick_nal_type()}};
                            ts_use = $urandom;
                        end
                        else
                        begin
                            frag_ts   = $urandom;
                            frag_open = 1'b1;
                            ts_use    = frag_ts;
                            pkt = {pkt, {3'($urandom_range(7)), NAL_TYPE_FUA}};
                            pkt = {pkt, FU_START_BIT | {3'b000, pick_nal_type()}};
                        end
                        repeat ($urandom_range(0, 2)) pkt = {pkt, 8'($urandom)};
                        send_packet(pkt, gen_seq, ts_use, 1'b0);
                    end
                    4:
                    begin
                        pkt = {pkt, {3'($urandom_range(7)), NAL_TYPE_FUA}};
                        send_packet(pkt, gen_seq, $urandom, 1'b1);
                    end
                    default:
                    begin
                        // empty marker cutting a single packet short
                        pkt = {pkt, {3'($urandom_range(7)), pick_nal_type()}};
                        repeat ($urandom_range(0, 2)) pkt = {pkt, 8'($urandom)};
                        ts_use = $urandom;
                        send_packet(pkt, gen_seq, ts_use, 1'b0);
                        send_byte(8'($urandom), 1'b0, 1'b0, 1'b1, gen_seq, ts_use);
                    end
                endcase
                gen_seq++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_nalu();
        test_fua_reassembly();
        test_fua_faults();
        test_invalid_packets();
        test_packet_marks();
        wait_drained();
        test_backpressure();
        test_random_streams(140, 1'b0);
        wait_drained();
        test_random_streams(150, 1'b1);
        wait_drained();

        $display("Run covered %0d payload bytes and %0d result transfers (%0d discards)",
                 bytes_sent, results_checked, discards_checked);
        $display("across single NAL, FU-A runs, sequence/timestamp faults, drops and stalls");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
src/hrfd_pkg.sv
src/hrfd_core.sv
src/hrfd_outbuf.sv
src/h264_rtp_fua_depacketizer.sv
tb/tb_h264_rtp_fua_depacketizer.sv
